// ===== design/insertion_sort_key_payload_core_macros.svh =====
// Assertion macros for the insertion sort core.
`ifndef INSERTION_SORT_KEY_PAYLOAD_CORE_MACROS_SVH
`define INSERTION_SORT_KEY_PAYLOAD_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ISK_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ISK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ISK_ASSERT(lbl, clk, rst_n, expr, msg)
`define ISK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== design/isk_pkg.sv =====
// Shared types and constants of the insertion sort core.
package isk_pkg;

  localparam int unsigned KeyW       = 32;
  localparam int unsigned PayloadW   = 32;
  localparam int unsigned MaxItemsDef = 32;

  typedef logic signed [KeyW-1:0]     key_t;
  typedef logic signed [PayloadW-1:0] payload_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

// ===== design/isk_if.sv =====
// Input and output stream interfaces of the insertion sort core.
interface isk_in_if import isk_pkg::*; ();
  logic     valid;
  logic     ready;
  key_t     key;
  payload_t payload;
  logic     last_in;

  modport source (output valid, output key, output payload, output last_in, input ready);
  modport sink   (input valid, input key, input payload, input last_in, output ready);
endinterface

interface isk_out_if import isk_pkg::*; ();
  logic     valid;
  logic     ready;
  key_t     sorted_key;
  payload_t sorted_payload;
  logic     last_out;
  logic     overflow;

  modport source (output valid, output sorted_key, output sorted_payload,
                  output last_out, output overflow, input ready);
  modport sink   (input valid, input sorted_key, input sorted_payload,
                  input last_out, input overflow, output ready);
endinterface

// ===== design/insertion_sort_key_payload_core.sv =====
// Top level of the stable insertion sort core for key and payload pairs.
//
// Input channel in_i carries a signed key, a payload and last_in. Each beat
// is inserted into a chain of MAX_ITEMS cells: every cell compares the new
// key at once and the greater entries move one cell right, so a batch
// streams in at one beat per cycle. The beat marked last_in closes the
// batch; the next cycle the block starts emitting on out_o. Emission reads
// each stored pair from the head cell while the chain shifts left,
// ascending by key, ties in arrival order. last_out marks the final pair,
// overflow is high on every pair of a batch in which a beat arrived at a
// full store and was dropped. in_i.ready is low during emission; a stall
// on out_o holds the head pair and the whole chain.
// Reset empties the store and clears the overflow flag; no clearing pass.
module insertion_sort_key_payload_core import isk_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  isk_in_if.sink        in_i,
  isk_out_if.source     out_o
);

  `include "insertion_sort_key_payload_core_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic ST_FILL = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic       in_fire, out_fire, full;
  cell_ctrl_t ctrl;

  key_t     cell_key [MAX_ITEMS];
  payload_t cell_pay [MAX_ITEMS];
  logic     cell_gt  [MAX_ITEMS];

  assign full        = (count_q == CntW'(MAX_ITEMS));
  assign in_i.ready  = (state_q == ST_FILL);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == ST_EMIT);
  assign out_fire    = out_o.valid && out_o.ready;

  assign ctrl.insert    = in_fire && !full;
  assign ctrl.shift_out = out_fire;

  assign out_o.sorted_key     = cell_key[0];
  assign out_o.sorted_payload = cell_pay[0];
  assign out_o.last_out       = (count_q == CntW'(1));
  assign out_o.overflow       = ovf_q;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isk_cell u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .occupied_i      (CntW'(i) < count_q),
      .new_key_i       (in_i.key),
      .new_payload_i   (in_i.payload),
      .left_gt_i       ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
      .left_key_i      (cell_key[(i == 0) ? 0 : i-1]),
      .left_payload_i  (cell_pay[(i == 0) ? 0 : i-1]),
      .right_key_i     (cell_key[(i == MAX_ITEMS-1) ? i : i+1]),
      .right_payload_i (cell_pay[(i == MAX_ITEMS-1) ? i : i+1]),
      .gt_o            (cell_gt[i]),
      .key_o           (cell_key[i]),
      .payload_o       (cell_pay[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.last_in) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = ST_FILL;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  `ISK_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_ITEMS), "fill count above capacity")
  `ISK_ASSERT(a_emit_nonempty, clk_i, rst_ni, !out_o.valid || (count_q != '0), "emitting from empty store")
  `ISK_ASSERT_NEXT(a_last_starts_emit, clk_i, rst_ni, in_fire && in_i.last_in, out_o.valid, "last beat did not start emission")
  `ISK_ASSERT_NEXT(a_emit_continues, clk_i, rst_ni, out_fire && !out_o.last_out, out_o.valid, "emission stopped before last pair")
  `ISK_ASSERT_NEXT(a_ovf_cleared, clk_i, rst_ni, out_fire && out_o.last_out, !out_o.overflow && in_i.ready, "batch state not cleared after emission")

endmodule

// ===== design/isk_cell.sv =====
// One cell of the sorting chain: holds a key and its payload.
module isk_cell import isk_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  key_t       new_key_i,
  input  payload_t   new_payload_i,
  input  logic       left_gt_i,
  input  key_t       left_key_i,
  input  payload_t   left_payload_i,
  input  key_t       right_key_i,
  input  payload_t   right_payload_i,
  output logic       gt_o,
  output key_t       key_o,
  output payload_t   payload_o
);

  key_t     key_q;
  payload_t payload_q;

  assign gt_o      = !occupied_i || (key_q > new_key_i);
  assign key_o     = key_q;
  assign payload_o = payload_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (gt_o) begin
        if (left_gt_i) begin
          key_q     <= left_key_i;
          payload_q <= left_payload_i;
        end else begin
          key_q     <= new_key_i;
          payload_q <= new_payload_i;
        end
      end
    end else if (ctrl_i.shift_out) begin
      key_q     <= right_key_i;
      payload_q <= right_payload_i;
    end
  end

endmodule

// ===== dv/insertion_sort_key_payload_core_test.sv =====
// Testbench for the insertion sort core: random batches checked against a stable sort.
module insertion_sort_key_payload_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isk_pkg::*;

  localparam int unsigned MaxItems    = MaxItemsDef;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 2 * MaxItems + 8;
  localparam key_t        KeyMin      = {1'b1, {(KeyW-1){1'b0}}};
  localparam key_t        KeyMax      = {1'b0, {(KeyW-1){1'b1}}};

  typedef struct {
    key_t     key;
    payload_t payload;
    logic     last;
  } beat_t;

  typedef struct {
    key_t     key;
    payload_t payload;
  } pair_t;

  typedef struct {
    key_t     key;
    payload_t payload;
    logic     last;
    logic     overflow;
  } sorted_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  isk_in_if  in_bus ();
  isk_out_if out_bus ();

  insertion_sort_key_payload_core #(
    .MAX_ITEMS(MaxItems)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  beat_t        pending_beats[$];
  pair_t        sort_store[$];
  sorted_pair_t expected_pairs[$];
  logic         batch_dropped = 1'b0;
  logic         in_taken      = 1'b0;
  int           sender_idle_pct   = 0;
  int           receiver_idle_pct = 0;
  int unsigned  stall_cycles    = 0;
  int unsigned  error_count     = 0;
  int unsigned  beats_in        = 0;
  int unsigned  pairs_checked   = 0;
  int unsigned  batches_closed  = 0;
  int unsigned  overflow_batches = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic key_t pick_key();
    case ($urandom_range(0, 3))
      0: return key_t'(int'($urandom_range(0, 6)) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return KeyMin;
          1: return KeyMax;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic void queue_beat(key_t k, payload_t p, logic last);
    pending_beats.push_back('{key: k, payload: p, last: last});
  endfunction

  function automatic void queue_batch(int n);
    for (int i = 0; i < n; i++) begin
      queue_beat(pick_key(), payload_t'($urandom), i == n - 1);
    end
  endfunction

  // Insert after every stored key that is less or equal; emit on the closing beat.
  function automatic void sort_beat(key_t k, payload_t p, logic last);
    int pos;
    int n;
    pos = sort_store.size();
    if (pos >= int'(MaxItems)) begin
      batch_dropped = 1'b1;
    end else begin
      while (pos > 0 && sort_store[pos-1].key > k) begin
        pos--;
      end
      sort_store.insert(pos, '{key: k, payload: p});
    end
    if (last) begin
      n = sort_store.size();
      for (int i = 0; i < n; i++) begin
        expected_pairs.push_back('{key: sort_store[i].key, payload: sort_store[i].payload,
                                   last: (i == n - 1), overflow: batch_dropped});
      end
      batches_closed++;
      if (batch_dropped) begin
        overflow_batches++;
      end
      sort_store.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    sorted_pair_t exp_pair;
    logic         in_fire;
    logic         out_fire;
    if (!rst_ni) begin
      in_taken     <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_fire  = in_bus.valid && in_bus.ready;
      out_fire = out_bus.valid && out_bus.ready;
      in_taken <= in_fire;
      if (in_fire) begin
        sort_beat(in_bus.key, in_bus.payload, in_bus.last_in);
        beats_in++;
      end
      if (out_fire) begin
        if (expected_pairs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat key %0d payload %h last %b overflow %b", $time,
                   out_bus.sorted_key, out_bus.sorted_payload, out_bus.last_out,
                   out_bus.overflow);
        end else begin
          exp_pair = expected_pairs.pop_front();
          if (out_bus.sorted_key !== exp_pair.key || out_bus.sorted_payload !== exp_pair.payload
              || out_bus.last_out !== exp_pair.last || out_bus.overflow !== exp_pair.overflow)
          begin
            error_count++;
            $display("%0t: expected key %0d payload %h last %b overflow %b", $time,
                     exp_pair.key, exp_pair.payload, exp_pair.last, exp_pair.overflow);
            $display("%0t: actual   key %0d payload %h last %b overflow %b", $time,
                     out_bus.sorted_key, out_bus.sorted_payload, out_bus.last_out,
                     out_bus.overflow);
          end
          pairs_checked++;
        end
      end
      if (in_fire || out_fire) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("timeout after %0d cycles without a beat", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    beat_t next_beat;
    out_bus.ready <= rst_ni && ($urandom_range(0, 99) >= receiver_idle_pct);
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_bus.valid   <= 1'b1;
        in_bus.key     <= next_beat.key;
        in_bus.payload <= next_beat.payload;
        in_bus.last_in <= next_beat.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  initial begin
    int added;
    int n;
    int r;
    in_bus.valid   = 1'b0;
    in_bus.key     = '0;
    in_bus.payload = '0;
    in_bus.last_in = 1'b0;
    out_bus.ready  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct   = 6;
          receiver_idle_pct = 75;
        end
        1: begin
          sender_idle_pct   = 75;
          receiver_idle_pct = 6;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase

      if (ph == 0) begin
        queue_beat(KeyMin, '1, 1'b1);
        queue_beat(KeyMax, '0, 1'b1);
        // extremes and ties: equal keys must leave in arrival order
        queue_beat(KeyMax, 32'h0000_0010, 1'b0);
        queue_beat(KeyMin, 32'h8000_0011, 1'b0);
        queue_beat('0, 32'h0000_0012, 1'b0);
        queue_beat('1, 32'hFFFF_0013, 1'b0);
        queue_beat(key_t'(5), 32'h5555_0014, 1'b0);
        queue_beat(key_t'(5), 32'hAAAA_0015, 1'b0);
        queue_beat('1, 32'h7FFF_0016, 1'b0);
        queue_beat(key_t'(5), 32'h0F0F_0017, 1'b1);
        for (int i = 0; i < 5; i++) begin
          queue_beat(key_t'(40 - 10 * i), payload_t'(i), i == 4);
        end
        for (int i = 0; i < 4; i++) begin
          queue_beat(key_t'(i - 2), payload_t'(32'hC000_0000 + i), i == 3);
        end
        queue_batch(MaxItems + 1);
      end else if (ph == 1) begin
        queue_batch(MaxItems);
      end else begin
        queue_batch(MaxItems + 4);
      end

      added = 0;
      while (added < 70) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          n = $urandom_range(MaxItems + 1, MaxItems + 6);
        end else if (r < 15) begin
          n = $urandom_range(9, MaxItems);
        end else begin
          n = $urandom_range(1, 8);
        end
        queue_batch(n);
        added += n;
      end

      while (pending_beats.size() != 0 || in_bus.valid) begin
        @(posedge clk_i);
      end
    end

    while (expected_pairs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sorted %0d batches from %0d input beats, %0d of them overflowed.",
             batches_closed, beats_in, overflow_batches);
    $display("Checked %0d output pairs across three pacing phases.", pairs_checked);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/isk_pkg.sv
design/isk_if.sv
design/isk_cell.sv
design/insertion_sort_key_payload_core.sv
dv/insertion_sort_key_payload_core_test.sv
